### rtl/spcg_pkg.sv
// Shared types, codes and constants for the sphere pair contact generator.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package spcg_pkg;

    // Default store depth (number of spheres per set)
    localparam int MAX_SPHERES_DEF = 8;

    // Q1.14 unit and tangent switch threshold (10*|nz| < 7*unit)
    localparam int UNIT_Q14  = 16384;
    localparam int TAN_LIMIT = 7 * UNIT_Q14;

    // Iteration counts of the shared root and divide units
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 16;

    // One input sphere
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [30:0]        sphere_radius;
        logic               is_static;
        logic               last_sphere;
    } sphere_t;

    // One output contact
    typedef struct packed {
        logic [2:0]         first_sphere;
        logic [2:0]         second_sphere;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic signed [15:0] tangent_x;
        logic signed [15:0] tangent_y;
        logic signed [15:0] tangent_z;
        logic signed [31:0] gap;
        logic [3:0]         first_body_number;
        logic [3:0]         second_body_number;
        logic               last_contact;
    } contact_t;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_READ,
        OP_DIFF,
        OP_SQ,
        OP_SQRT,
        OP_GAP,
        OP_DIV,
        OP_TSEL,
        OP_TUNIT,
        OP_EMIT,
        OP_CLEAR
    } dp_op_t;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIND,
        ST_READ,
        ST_DIFF,
        ST_SQ,
        ST_SQRT,
        ST_SQRT_WAIT,
        ST_GAP,
        ST_DIV,
        ST_DIV_WAIT,
        ST_TSEL,
        ST_LOOK,
        ST_EMIT,
        ST_DONE
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed {
        dp_op_t     op;
        logic [1:0] k;      // axis / square step
        logic       tang;   // 0: normal phase, 1: tangent phase
        logic       last;   // final contact of the set
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic busy;         // root or divide unit running
        logic root_zero;    // last root result is zero
        logic out_free;     // output register can take a contact
    } sts_t;

endpackage

### rtl/spcg_if.sv
// Handshake channel interfaces for sphere input and contact output.
// No dependencies.
`timescale 1ns / 1ps

interface spcg_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [30:0]        sphere_radius;
    logic               is_static;
    logic               last_sphere;

    modport source (output valid, pos_x, pos_y, pos_z, sphere_radius, is_static,
                    last_sphere, input ready);
    modport sink (input valid, pos_x, pos_y, pos_z, sphere_radius, is_static,
                  last_sphere, output ready);
endinterface

interface spcg_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         first_sphere;
    logic [2:0]         second_sphere;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [15:0] tangent_x;
    logic signed [15:0] tangent_y;
    logic signed [15:0] tangent_z;
    logic signed [31:0] gap;
    logic [3:0]         first_body_number;
    logic [3:0]         second_body_number;
    logic               last_contact;

    modport source (output valid, first_sphere, second_sphere, normal_x, normal_y,
                    normal_z, tangent_x, tangent_y, tangent_z, gap,
                    first_body_number, second_body_number, last_contact,
                    input ready);
    modport sink (input valid, first_sphere, second_sphere, normal_x, normal_y,
                  normal_z, tangent_x, tangent_y, tangent_z, gap,
                  first_body_number, second_body_number, last_contact,
                  output ready);
endinterface

### rtl/spcg_dp.sv
// Datapath: sphere store, difference/square unit, shared root and divide
// units, tangent select, body numbering and output register. Uses spcg_pkg.
`timescale 1ns / 1ps

module spcg_dp
    import spcg_pkg::*;
#(
    parameter int MAX_SPHERES = MAX_SPHERES_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  cmd_t                           cmd,
    input  logic [$clog2(MAX_SPHERES)-1:0] idx_a,
    input  logic [$clog2(MAX_SPHERES)-1:0] idx_b,
    input  sphere_t                        sphere,
    input  logic                           out_ready,
    output logic                           out_valid,
    output contact_t                       contact,
    output sts_t                           sts,
    output logic [MAX_SPHERES-1:0]         static_vec
);

    // Sphere store
    logic [31:0] mem_x [MAX_SPHERES];
    logic [31:0] mem_y [MAX_SPHERES];
    logic [31:0] mem_z [MAX_SPHERES];
    logic [30:0] mem_r [MAX_SPHERES];
    logic [3:0]  mem_bn [MAX_SPHERES];
    logic [MAX_SPHERES-1:0] static_reg;
    logic [MAX_SPHERES-1:0] bv_reg;     // body number assigned this set
    logic [3:0]  nb_reg;

    // Pair operands
    logic [31:0] xa_reg, ya_reg, za_reg, xb_reg, yb_reg, zb_reg;
    logic [30:0] ra_reg, rb_reg;
    logic        sta_reg, stb_reg, bva_reg, bvb_reg;
    logic [3:0]  bna_reg, bnb_reg;

    // Normal phase
    logic [31:0] mag_reg [3];
    logic        neg_reg [3];
    logic        coarse_reg;
    logic [63:0] prod_reg, acc_reg;
    logic signed [31:0] gap_reg;
    logic signed [15:0] n_reg [3];
    logic signed [15:0] t_reg [3];
    logic [14:0] vm_reg [3];
    logic        tneg_reg [3];

    // Root unit
    logic [63:0] sv_reg, sr_reg, sb_reg;
    logic [4:0]  scnt_reg;
    logic        sbusy_reg;

    // Divide unit
    logic [47:0] num_reg, dsh_reg;
    logic [15:0] q_reg;
    logic [3:0]  dcnt_reg;
    logic        dbusy_reg;
    logic [1:0]  dk_reg;
    logic        dtang_reg, dneg_reg;

    logic        out_valid_reg;
    contact_t    out_reg;

    // Combinational helpers
    logic signed [32:0] d [3];
    logic [31:0] dm [3];
    logic        coarse;
    logic [31:0] msel;
    logic [63:0] sq_sum;
    logic        sq_ge;
    logic [31:0] root;
    logic [33:0] dist_ext;
    logic signed [35:0] gap_full;
    logic [31:0] dmag;
    logic        dneg;
    logic        div_ge;
    logic [15:0] qf;
    logic [15:0] qres;
    logic [14:0] az;
    logic [18:0] az10;
    logic signed [16:0] v [3];
    logic [3:0]  b_num;
    logic        b_new;

    assign root = sr_reg[31:0];

    // Per-axis difference and magnitude
    assign d[0] = $signed({xb_reg[31], xb_reg}) - $signed({xa_reg[31], xa_reg});
    assign d[1] = $signed({yb_reg[31], yb_reg}) - $signed({ya_reg[31], ya_reg});
    assign d[2] = $signed({zb_reg[31], zb_reg}) - $signed({za_reg[31], za_reg});
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            dm[k] = d[k][32] ? 32'(-d[k]) : 32'(d[k]);
        end
        coarse = dm[0][31] | dm[1][31] | dm[2][31];
    end

    // Square operand select
    always_comb
    begin
        case (cmd.k)
            2'd0:    msel = cmd.tang ? {17'd0, vm_reg[0]} : mag_reg[0];
            2'd1:    msel = cmd.tang ? {17'd0, vm_reg[1]} : mag_reg[1];
            2'd2:    msel = cmd.tang ? {17'd0, vm_reg[2]} : mag_reg[2];
            default: msel = '0;
        endcase
    end

    // Root step
    assign sq_sum = sr_reg + sb_reg;
    assign sq_ge  = sv_reg >= sq_sum;

    // Gap with saturation
    assign dist_ext = coarse_reg ? {1'b0, root, 1'b0} : {2'b00, root};
    assign gap_full = $signed({2'b00, dist_ext}) - $signed({5'd0, ra_reg})
                    - $signed({5'd0, rb_reg});

    // Divide operand select and step
    always_comb
    begin
        case (cmd.k)
            2'd0:
            begin
                dmag = cmd.tang ? {17'd0, vm_reg[0]} : mag_reg[0];
                dneg = cmd.tang ? tneg_reg[0] : neg_reg[0];
            end
            2'd1:
            begin
                dmag = cmd.tang ? {17'd0, vm_reg[1]} : mag_reg[1];
                dneg = cmd.tang ? tneg_reg[1] : neg_reg[1];
            end
            default:
            begin
                dmag = cmd.tang ? {17'd0, vm_reg[2]} : mag_reg[2];
                dneg = cmd.tang ? tneg_reg[2] : neg_reg[2];
            end
        endcase
    end
    assign div_ge = num_reg >= dsh_reg;
    assign qf     = {q_reg[14:0], div_ge};
    assign qres   = dneg_reg ? (16'd0 - qf) : qf;

    // Tangent source vector
    assign az   = n_reg[2][15] ? 15'(-n_reg[2]) : 15'(n_reg[2]);
    assign az10 = {1'b0, az, 3'b000} + {3'b000, az, 1'b0};
    always_comb
    begin
        if (az10 < 19'(TAN_LIMIT))
        begin
            v[0] = 17'(n_reg[1]);
            v[1] = -17'(n_reg[0]);
            v[2] = '0;
        end
        else
        begin
            v[0] = -17'(n_reg[2]);
            v[1] = '0;
            v[2] = 17'(n_reg[0]);
        end
    end

    // Second body number
    assign b_new = !stb_reg && !bvb_reg;
    assign b_num = stb_reg ? 4'd0 : (bvb_reg ? bnb_reg : nb_reg);

    // Store writes and pair reads
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD)
        begin
            mem_x[idx_a]      <= sphere.pos_x;
            mem_y[idx_a]      <= sphere.pos_y;
            mem_z[idx_a]      <= sphere.pos_z;
            mem_r[idx_a]      <= sphere.sphere_radius;
            static_reg[idx_a] <= sphere.is_static;
        end
        if (cmd.op == OP_READ)
        begin
            xa_reg  <= mem_x[idx_a];
            ya_reg  <= mem_y[idx_a];
            za_reg  <= mem_z[idx_a];
            ra_reg  <= mem_r[idx_a];
            xb_reg  <= mem_x[idx_b];
            yb_reg  <= mem_y[idx_b];
            zb_reg  <= mem_z[idx_b];
            rb_reg  <= mem_r[idx_b];
            bna_reg <= mem_bn[idx_a];
            bnb_reg <= mem_bn[idx_b];
            sta_reg <= static_reg[idx_a];
            stb_reg <= static_reg[idx_b];
        end
        if (cmd.op == OP_TSEL && !sta_reg && !bva_reg)
        begin
            mem_bn[idx_a] <= nb_reg;
            bna_reg       <= nb_reg;
        end
        if (cmd.op == OP_EMIT && b_new)
        begin
            mem_bn[idx_b] <= nb_reg;
        end
    end

    // Body number bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bv_reg  <= '0;
            nb_reg  <= 4'd1;
            bva_reg <= 1'b0;
            bvb_reg <= 1'b0;
        end
        else
        begin
            case (cmd.op)
                OP_READ:
                begin
                    bva_reg <= bv_reg[idx_a];
                    bvb_reg <= bv_reg[idx_b];
                end
                OP_TSEL:
                begin
                    if (!sta_reg && !bva_reg)
                    begin
                        bv_reg[idx_a] <= 1'b1;
                        bva_reg       <= 1'b1;
                        nb_reg        <= nb_reg + 4'd1;
                    end
                end
                OP_EMIT:
                begin
                    if (b_new)
                    begin
                        bv_reg[idx_b] <= 1'b1;
                        nb_reg        <= nb_reg + 4'd1;
                    end
                end
                OP_CLEAR:
                begin
                    bv_reg <= '0;
                    nb_reg <= 4'd1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Difference, squares, gap and tangent select
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_DIFF:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    mag_reg[k] <= coarse ? {1'b0, dm[k][31:1]} : dm[k];
                    neg_reg[k] <= d[k][32];
                end
                coarse_reg <= coarse;
            end
            OP_SQ:
            begin
                prod_reg <= msel * msel;
                acc_reg  <= (cmd.k == 2'd0) ? '0 : acc_reg + prod_reg;
            end
            OP_GAP:
            begin
                if (gap_full > 36'sh0_7FFF_FFFF)
                    gap_reg <= 32'sh7FFF_FFFF;
                else if (gap_full < 36'shF_8000_0000)
                    gap_reg <= 32'sh8000_0000;
                else
                    gap_reg <= gap_full[31:0];
            end
            OP_TSEL:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    vm_reg[k]   <= v[k][16] ? 15'(-v[k]) : 15'(v[k]);
                    tneg_reg[k] <= v[k][16];
                end
            end
            default:
            begin
            end
        endcase
    end

    // Root and divide unit control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sbusy_reg <= 1'b0;
            dbusy_reg <= 1'b0;
        end
        else
        begin
            if (cmd.op == OP_SQRT)
                sbusy_reg <= 1'b1;
            else if (sbusy_reg && scnt_reg == '0)
                sbusy_reg <= 1'b0;
            if (cmd.op == OP_DIV)
                dbusy_reg <= 1'b1;
            else if (dbusy_reg && dcnt_reg == '0)
                dbusy_reg <= 1'b0;
        end
    end

    // Root unit: bit-serial square root of the summed squares
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_SQRT)
        begin
            sv_reg   <= acc_reg;
            sr_reg   <= '0;
            sb_reg   <= 64'h4000_0000_0000_0000;
            scnt_reg <= 5'(SQRT_STEPS - 1);
        end
        else if (sbusy_reg)
        begin
            if (sq_ge)
            begin
                sv_reg <= sv_reg - sq_sum;
                sr_reg <= (sr_reg >> 1) + sb_reg;
            end
            else
            begin
                sr_reg <= sr_reg >> 1;
            end
            sb_reg   <= sb_reg >> 2;
            scnt_reg <= scnt_reg - 5'd1;
        end
    end

    // Divide unit: one quotient bit per cycle, results land in n or t
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_DIV)
        begin
            num_reg   <= {2'b00, dmag, 14'd0} + {17'd0, root[31:1]};
            dsh_reg   <= {1'b0, root, 15'd0};
            q_reg     <= '0;
            dcnt_reg  <= 4'(DIV_STEPS - 1);
            dk_reg    <= cmd.k;
            dtang_reg <= cmd.tang;
            dneg_reg  <= dneg;
        end
        else if (dbusy_reg)
        begin
            if (div_ge)
                num_reg <= num_reg - dsh_reg;
            dsh_reg  <= dsh_reg >> 1;
            q_reg    <= qf;
            dcnt_reg <= dcnt_reg - 4'd1;
        end
        if (dbusy_reg && dcnt_reg == '0)
        begin
            if (dtang_reg)
                t_reg[dk_reg] <= qres;
            else
                n_reg[dk_reg] <= qres;
        end
        // Coincident centers and zero tangent length
        if (cmd.op == OP_GAP && sr_reg == '0)
        begin
            n_reg[0] <= '0;
            n_reg[1] <= '0;
            n_reg[2] <= 16'(UNIT_Q14);
        end
        if (cmd.op == OP_TUNIT)
        begin
            t_reg[0] <= 16'(UNIT_Q14);
            t_reg[1] <= '0;
            t_reg[2] <= '0;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.op == OP_EMIT)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_EMIT)
        begin
            out_reg.first_sphere       <= 3'(idx_a);
            out_reg.second_sphere      <= 3'(idx_b);
            out_reg.normal_x           <= n_reg[0];
            out_reg.normal_y           <= n_reg[1];
            out_reg.normal_z           <= n_reg[2];
            out_reg.tangent_x          <= t_reg[0];
            out_reg.tangent_y          <= t_reg[1];
            out_reg.tangent_z          <= t_reg[2];
            out_reg.gap                <= gap_reg;
            out_reg.first_body_number  <= sta_reg ? 4'd0 : bna_reg;
            out_reg.second_body_number <= b_num;
            out_reg.last_contact       <= cmd.last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign contact       = out_reg;
    assign static_vec    = static_reg;
    assign sts.busy      = sbusy_reg | dbusy_reg;
    assign sts.root_zero = (sr_reg == '0);
    assign sts.out_free  = !out_valid_reg || out_ready;

endmodule

### rtl/spcg_ctrl.sv
// Controller: sphere loading, pair walk with look-ahead for the final
// contact, and sequencing of the datapath operations. Uses spcg_pkg.
`timescale 1ns / 1ps

module spcg_ctrl
    import spcg_pkg::*;
#(
    parameter int MAX_SPHERES = MAX_SPHERES_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_fire,
    input  logic                           in_last,
    input  sts_t                           sts,
    input  logic [MAX_SPHERES-1:0]         static_vec,
    output logic                           in_ready,
    output cmd_t                           cmd,
    output logic [$clog2(MAX_SPHERES)-1:0] idx_a,
    output logic [$clog2(MAX_SPHERES)-1:0] idx_b
);

    localparam int IDX_W = $clog2(MAX_SPHERES);
    localparam int CNT_W = $clog2(MAX_SPHERES + 1);
    localparam int SW    = $clog2(MAX_SPHERES + 2);

    ctrl_state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] ci_reg, ci_next, cj_reg, cj_next;
    logic [SW-1:0]    si_reg, si_next, sj_reg, sj_next;
    logic [1:0]       k_reg, k_next;
    logic             tang_reg, tang_next;
    logic             last_reg, last_next;

    logic [SW-1:0] ni, nj, cnt_w;
    logic          scan_end, scan_hit, has_room;

    // Pair scan: step to the next (i, j) and test it
    assign cnt_w    = SW'(cnt_reg);
    assign has_room = cnt_reg < CNT_W'(MAX_SPHERES);
    always_comb
    begin
        if (sj_reg + SW'(1) < cnt_w)
        begin
            ni = si_reg;
            nj = sj_reg + SW'(1);
        end
        else
        begin
            ni = si_reg + SW'(1);
            nj = si_reg + SW'(2);
        end
        scan_end = nj >= cnt_w;
        scan_hit = !scan_end
                 && !(static_vec[ni[IDX_W-1:0]] && static_vec[nj[IDX_W-1:0]]);
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            ci_reg    <= '0;
            cj_reg    <= '0;
            si_reg    <= '0;
            sj_reg    <= '0;
            k_reg     <= '0;
            tang_reg  <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ci_reg    <= ci_next;
            cj_reg    <= cj_next;
            si_reg    <= si_next;
            sj_reg    <= sj_next;
            k_reg     <= k_next;
            tang_reg  <= tang_next;
            last_reg  <= last_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ci_next    = ci_reg;
        cj_next    = cj_reg;
        si_next    = si_reg;
        sj_next    = sj_reg;
        k_next     = k_reg;
        tang_next  = tang_reg;
        last_next  = last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (has_room)
                        cnt_next = cnt_reg + CNT_W'(1);
                    if (in_last)
                    begin
                        si_next    = '0;
                        sj_next    = '0;
                        state_next = ST_FIND;
                    end
                end
            end
            ST_FIND:
            begin
                if (scan_end)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    si_next = ni;
                    sj_next = nj;
                    if (scan_hit)
                    begin
                        ci_next    = ni[IDX_W-1:0];
                        cj_next    = nj[IDX_W-1:0];
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                k_next     = '0;
                tang_next  = 1'b0;
                state_next = ST_SQ;
            end
            ST_SQ:
            begin
                k_next = k_reg + 2'd1;
                if (k_reg == 2'd3)
                    state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                state_next = ST_SQRT_WAIT;
            end
            ST_SQRT_WAIT:
            begin
                if (!sts.busy)
                begin
                    k_next = '0;
                    if (!tang_reg)
                        state_next = ST_GAP;
                    else if (sts.root_zero)
                        state_next = ST_LOOK;
                    else
                        state_next = ST_DIV;
                end
            end
            ST_GAP:
            begin
                k_next     = '0;
                state_next = sts.root_zero ? ST_TSEL : ST_DIV;
            end
            ST_DIV:
            begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (!sts.busy)
                begin
                    if (k_reg == 2'd2)
                    begin
                        state_next = tang_reg ? ST_LOOK : ST_TSEL;
                    end
                    else
                    begin
                        k_next     = k_reg + 2'd1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_TSEL:
            begin
                k_next     = '0;
                tang_next  = 1'b1;
                state_next = ST_SQ;
            end
            ST_LOOK:
            begin
                if (scan_end)
                begin
                    last_next  = 1'b1;
                    state_next = ST_EMIT;
                end
                else
                begin
                    si_next = ni;
                    sj_next = nj;
                    if (scan_hit)
                    begin
                        last_next  = 1'b0;
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    if (last_reg)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        ci_next    = si_reg[IDX_W-1:0];
                        cj_next    = sj_reg[IDX_W-1:0];
                        state_next = ST_READ;
                    end
                end
            end
            ST_DONE:
            begin
                cnt_next   = '0;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready = 1'b0;
        cmd.op   = OP_NOP;
        cmd.k    = k_reg;
        cmd.tang = tang_reg;
        cmd.last = last_reg;
        idx_a    = ci_reg;
        idx_b    = cj_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                idx_a    = cnt_reg[IDX_W-1:0];
                if (in_fire && has_room)
                    cmd.op = OP_LOAD;
            end
            ST_READ:      cmd.op = OP_READ;
            ST_DIFF:      cmd.op = OP_DIFF;
            ST_SQ:        cmd.op = OP_SQ;
            ST_SQRT:      cmd.op = OP_SQRT;
            ST_SQRT_WAIT:
            begin
                if (!sts.busy && tang_reg && sts.root_zero)
                    cmd.op = OP_TUNIT;
            end
            ST_GAP:       cmd.op = OP_GAP;
            ST_DIV:       cmd.op = OP_DIV;
            ST_TSEL:      cmd.op = OP_TSEL;
            ST_EMIT:
            begin
                if (sts.out_free)
                    cmd.op = OP_EMIT;
            end
            ST_DONE:      cmd.op = OP_CLEAR;
            default:
            begin
            end
        endcase
    end

endmodule

### rtl/sphere_pair_contact_generator_core.sv
// Top level of the sphere pair contact generator: controller plus datapath.
// Depends on spcg_pkg, spcg_if, spcg_ctrl and spcg_dp.
`timescale 1ns / 1ps
//
//  channel   dir   carries                       transfer when
//  in_ch     in    one sphere (last_sphere ends)  valid && ready
//  out_ch    out   one contact per non-static pair valid && ready
//
//  After the last sphere the pairs are walked in order; each contact uses two
//  32-step root passes and up to six 16-step divides on the shared units, and
//  pairs of two static spheres are skipped. rst_n clears the controller, output
//  valid and body numbers. A stalled output holds the walk at the emit step;
//  spheres are taken only between sets.

module sphere_pair_contact_generator_core
    import spcg_pkg::*;
#(
    parameter int MAX_SPHERES = MAX_SPHERES_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    spcg_in_if.sink   in_ch,
    spcg_out_if.source out_ch
);

    localparam int IDX_W = $clog2(MAX_SPHERES);

    cmd_t                   cmd;
    sts_t                   sts;
    logic [IDX_W-1:0]       idx_a, idx_b;
    logic [MAX_SPHERES-1:0] static_vec;
    logic                   in_ready;
    logic                   in_fire;
    sphere_t                sphere;
    contact_t               contact;
    logic                   out_valid;

    // Input side
    assign in_ch.ready = in_ready;
    assign in_fire     = in_ch.valid && in_ready;
    assign sphere.pos_x         = in_ch.pos_x;
    assign sphere.pos_y         = in_ch.pos_y;
    assign sphere.pos_z         = in_ch.pos_z;
    assign sphere.sphere_radius = in_ch.sphere_radius;
    assign sphere.is_static     = in_ch.is_static;
    assign sphere.last_sphere   = in_ch.last_sphere;

    spcg_ctrl #(
        .MAX_SPHERES(MAX_SPHERES)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_fire    (in_fire),
        .in_last    (in_ch.last_sphere),
        .sts        (sts),
        .static_vec (static_vec),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .idx_a      (idx_a),
        .idx_b      (idx_b)
    );

    spcg_dp #(
        .MAX_SPHERES(MAX_SPHERES)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .idx_a      (idx_a),
        .idx_b      (idx_b),
        .sphere     (sphere),
        .out_ready  (out_ch.ready),
        .out_valid  (out_valid),
        .contact    (contact),
        .sts        (sts),
        .static_vec (static_vec)
    );

    // Output side
    assign out_ch.valid              = out_valid;
    assign out_ch.first_sphere       = contact.first_sphere;
    assign out_ch.second_sphere      = contact.second_sphere;
    assign out_ch.normal_x           = contact.normal_x;
    assign out_ch.normal_y           = contact.normal_y;
    assign out_ch.normal_z           = contact.normal_z;
    assign out_ch.tangent_x          = contact.tangent_x;
    assign out_ch.tangent_y          = contact.tangent_y;
    assign out_ch.tangent_z          = contact.tangent_z;
    assign out_ch.gap                = contact.gap;
    assign out_ch.first_body_number  = contact.first_body_number;
    assign out_ch.second_body_number = contact.second_body_number;
    assign out_ch.last_contact       = contact.last_contact;

`ifndef SYNTH
    // Spheres are only taken while the shared units are quiet
    assert property (@(posedge clk) disable iff (!rst_n) in_ready |-> !sts.busy)
        else $error("input ready while root/divide unit busy");

    // A new contact is only loaded when the output register frees up
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_EMIT) |-> sts.out_free)
        else $error("contact loaded over an unsent contact");

    // Emitted normal x and z components stay within the unit range
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (contact.normal_x <= 16'sd16384 && contact.normal_x >= -16'sd16384
                    && contact.normal_z <= 16'sd16384 && contact.normal_z >= -16'sd16384))
        else $error("normal component out of range");

    // Pair indices ascend when they fit the output field
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && MAX_SPHERES <= 8) |-> contact.first_sphere < contact.second_sphere)
        else $error("pair indices out of order");
`endif

endmodule
